// ===== rtl/core/pes_packet_header_parser_assert.svh =====
// Assertion macros shared by the parser RTL.
`ifndef PES_PACKET_HEADER_PARSER_ASSERT_SVH
`define PES_PACKET_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PPP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define PPP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/ppp_pkg.sv =====
// ----------------------------------------------------------------------------
// ppp_pkg
// Types, start codes and helpers for the program-stream PES header parser.
// ----------------------------------------------------------------------------
package ppp_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [32:0] stamp_t;

	localparam logic [15:0] CODE_PACK      = 16'h01BA;
	localparam logic [15:0] CODE_SYSTEM    = 16'h01BB;
	localparam logic [15:0] CODE_MAP       = 16'h01BC;
	localparam logic [15:0] CODE_PRIV1     = 16'h01BD;
	localparam logic [15:0] CODE_PADDING   = 16'h01BE;
	localparam logic [15:0] CODE_PRIV2     = 16'h01BF;
	localparam logic [15:0] CODE_AUDIO_LO  = 16'h01C0;
	localparam logic [15:0] CODE_VIDEO_HI  = 16'h01EF;
	localparam logic [15:0] CODE_EXT       = 16'h01FD;

	localparam logic [19:0] SYNC_LIMIT_RESET = 20'd100000;
	localparam logic        REG_SYNC_LIMIT   = 1'b0;

	// Assembles a 33-bit time stamp from the five bytes held in the shifter.
	function automatic stamp_t stamp_value(input logic [39:0] sh);
		stamp_value = {sh[35:33], sh[31:17], sh[15:1]};
	endfunction

endpackage

// ===== rtl/core/pes_packet_header_parser.sv =====
// ----------------------------------------------------------------------------
// pes_packet_header_parser
// Hunts for start codes in a program stream and emits PES headers and bytes.
// ----------------------------------------------------------------------------
// The input channel carries one stream byte per beat, with restart marking the
// end of a stream; a restart beat carries no byte and sends the parser back to
// the hunt. The output channel carries one item per beat: a header item
// (kind 0) with stream id, time stamps and payload length, then one payload
// item (kind 1) per payload byte, with last set on the final item of a packet.
// Many input beats produce no output beat at all.
// A beat accepted into the input register is parsed from there, and its item,
// if any, is then registered into the output register; one beat per cycle is
// sustained while the receiver does not stall, the per-byte parser state
// update being the register loop that sets this rate.
// When the receiver stalls and the output register is full, the input stalls
// once its register is also full; nothing is lost or repeated.
// Reset clears the parser to the hunt and sets sync_limit to 100000. The
// sync_limit register lies at byte address 0 of the APB port; the user must
// write it only while the parser is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module pes_packet_header_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  ppp_pkg::byte_t        in_byte,
	input  logic                  restart,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  kind,
	output logic [15:0]           stream_id,
	output logic                  pts_valid,
	output ppp_pkg::stamp_t       pts,
	output ppp_pkg::stamp_t       dts,
	output logic [15:0]           payload_length,
	output ppp_pkg::byte_t        payload_byte,
	output logic                  last,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import ppp_pkg::*;

	typedef enum logic [4:0] {
		PH_SEARCH, PH_LEN_HI, PH_LEN_LO, PH_SKIP, PH_STUFF, PH_BUF1, PH_BUF2,
		PH_PTS1, PH_DTS1, PH_FLAGS, PH_HLEN, PH_PTS2, PH_DTS2, PH_PESEXT,
		PH_EXTSKIP, PH_EXT2LEN, PH_IDEXT, PH_HSKIP, PH_PAYLOAD
	} phase_t;

	logic [19:0] sync_limit_q;

	logic        valid_s1;
	byte_t       byte_s1;
	logic        restart_s1;

	phase_t             phase_q, n_phase;
	logic [23:0]        shift_q, n_shift;
	logic [19:0]        count_q, n_count;
	logic [15:0]        code_q, n_code;
	logic signed [17:0] len_q, n_len;
	logic signed [9:0]  hdr_q, n_hdr;
	logic [7:0]         hflags_q, n_hflags;
	logic [7:0]         eflags_q, n_eflags;
	logic [39:0]        stamp_q, n_stamp;
	logic [3:0]         fidx_q, n_fidx;
	logic               ptsv_q, n_ptsv;
	stamp_t             pts_q, n_pts;
	stamp_t             dts_q, n_dts;

	logic        out_valid_q;
	logic        kind_q, ptsv_out_q, last_q;
	logic [15:0] id_q, plen_q;
	stamp_t      pts_out_q, dts_out_q;
	byte_t       pbyte_q;

	logic        emit, e_kind, e_last;
	logic        go;
	logic        t_flags, t_ext, t_finish, t_done, stamp_full;
	logic [4:0]  skip;

	assign pready   = 1'b1;
	assign prdata   = {12'd0, sync_limit_q};
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign go       = valid_s1 && !(out_valid_q && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_limit_q <= SYNC_LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_SYNC_LIMIT) begin
			sync_limit_q <= pwdata[19:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1    <= in_byte;
			restart_s1 <= restart;
		end
	end

	always_comb begin
		n_phase = phase_q; n_shift = shift_q; n_count = count_q; n_code = code_q;
		n_len = len_q; n_hdr = hdr_q; n_hflags = hflags_q; n_eflags = eflags_q;
		n_stamp = stamp_q; n_fidx = fidx_q; n_ptsv = ptsv_q; n_pts = pts_q;
		n_dts = dts_q;
		emit = 1'b0; e_kind = 1'b0; e_last = 1'b0;
		t_flags = 1'b0; t_ext = 1'b0; t_finish = 1'b0; t_done = 1'b0;
		skip = 5'd0;
		stamp_full = 1'b0;

		if (phase_q == PH_PTS1 || phase_q == PH_DTS1 || phase_q == PH_PTS2 ||
				phase_q == PH_DTS2) begin
			n_stamp    = {stamp_q[31:0], byte_s1};
			n_fidx     = fidx_q + 4'd1;
			stamp_full = (n_fidx >= 4'd5);
		end

		if (restart_s1) begin
			n_phase = PH_SEARCH; n_shift = 24'hFF; n_count = '0;
		end else begin
			unique case (phase_q)
				PH_SEARCH: begin
					n_count = count_q + 20'd1;
					if (shift_q == 24'd1) begin
						n_code  = {8'h01, byte_s1};
						n_shift = 24'hFF; n_count = '0;
						n_phase = (n_code != CODE_PACK && n_code != CODE_SYSTEM) ?
							PH_LEN_HI : PH_SEARCH;
					end else begin
						n_shift = {shift_q[15:0], byte_s1};
						if (n_count >= sync_limit_q) begin
							n_shift = 24'hFF; n_count = '0;
						end
					end
				end
				PH_LEN_HI: begin
					n_len   = signed'({2'b00, byte_s1, 8'h00});
					n_phase = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					n_len = signed'({2'b00, len_q[15:8], byte_s1});
					if (code_q == CODE_PADDING || code_q == CODE_PRIV2 ||
							code_q == CODE_MAP) begin
						n_phase = (n_len == 0) ? PH_SEARCH : PH_SKIP;
					end else if ((code_q >= CODE_AUDIO_LO && code_q <= CODE_VIDEO_HI) ||
							code_q == CODE_PRIV1 || code_q == CODE_EXT) begin
						n_ptsv = 1'b0; n_pts = '0; n_dts = '0;
						n_phase = (n_len < 1) ? PH_SEARCH : PH_STUFF;
					end else begin
						n_phase = PH_SEARCH;
					end
					if (n_phase == PH_SEARCH) begin
						n_shift = 24'hFF; n_count = '0;
					end
				end
				PH_SKIP: begin
					n_len = len_q - 18'sd1;
					if (n_len <= 0) begin
						n_phase = PH_SEARCH; n_shift = 24'hFF; n_count = '0;
					end
				end
				PH_STUFF, PH_BUF2: begin
					n_len = (phase_q == PH_STUFF) ? len_q - 18'sd1 : len_q - 18'sd2;
					if (phase_q == PH_STUFF && byte_s1 == 8'hFF) begin
						if (n_len < 1) begin
							n_phase = PH_SEARCH; n_shift = 24'hFF; n_count = '0;
						end
					end else if (phase_q == PH_STUFF && byte_s1[7:6] == 2'b01) begin
						n_phase = PH_BUF1;
					end else if (byte_s1[7:5] == 3'b001) begin
						n_stamp = {32'd0, byte_s1}; n_fidx = 4'd1; n_phase = PH_PTS1;
					end else if (byte_s1[7:6] == 2'b10) begin
						n_phase = PH_FLAGS;
					end else if (byte_s1 == 8'h0F) begin
						t_done = 1'b1;
					end else begin
						n_phase = PH_SEARCH; n_shift = 24'hFF; n_count = '0;
					end
				end
				PH_BUF1: n_phase = PH_BUF2;
				PH_PTS1: begin
					if (stamp_full) begin
						n_ptsv = 1'b1; n_pts = stamp_value(n_stamp); n_dts = n_pts;
						n_len  = len_q - 18'sd4;
						if (n_stamp[36]) begin
							n_fidx = '0; n_phase = PH_DTS1;
						end else begin
							t_done = 1'b1;
						end
					end
				end
				PH_DTS1: begin
					if (stamp_full) begin
						n_dts = stamp_value(n_stamp); n_len = len_q - 18'sd5; t_done = 1'b1;
					end
				end
				PH_FLAGS: begin
					n_hflags = byte_s1; n_phase = PH_HLEN;
				end
				PH_HLEN: begin
					n_len = len_q - 18'sd2;
					n_hdr = signed'({2'b00, byte_s1});
					if (18'(n_hdr) > n_len) begin
						n_phase = PH_SEARCH; n_shift = 24'hFF; n_count = '0;
					end else begin
						n_len = n_len - 18'(n_hdr);
						if (hflags_q[7]) begin
							n_fidx = '0; n_phase = PH_PTS2;
						end else begin
							t_flags = 1'b1;
						end
					end
				end
				PH_PTS2: begin
					if (stamp_full) begin
						n_ptsv = 1'b1; n_pts = stamp_value(n_stamp); n_dts = n_pts;
						n_hdr  = hdr_q - 10'sd5;
						if (hflags_q[6]) begin
							n_fidx = '0; n_phase = PH_DTS2;
						end else begin
							t_flags = 1'b1;
						end
					end
				end
				PH_DTS2: begin
					if (stamp_full) begin
						n_dts = stamp_value(n_stamp); n_hdr = hdr_q - 10'sd5; t_flags = 1'b1;
					end
				end
				PH_PESEXT: begin
					n_hdr = hdr_q - 10'sd1;
					// Optional PES fields of 2, 2 and 16 bytes sit ahead of the extension 2.
					skip = (byte_s1[4] ? 5'd2 : 5'd0) + (byte_s1[5] ? 5'd2 : 5'd0) +
						(byte_s1[7] ? 5'd16 : 5'd0);
					// The header count may already be negative here, so compare signed.
					if (byte_s1[6] || signed'({5'd0, skip}) > n_hdr) begin
						n_eflags = '0; t_ext = 1'b1;
					end else begin
						n_eflags = byte_s1;
						n_hdr    = n_hdr - 10'(skip);
						if (skip == 5'd0) begin
							t_ext = 1'b1;
						end else begin
							n_stamp = {35'd0, skip}; n_phase = PH_EXTSKIP;
						end
					end
				end
				PH_EXTSKIP: begin
					n_stamp = stamp_q - 40'd1;
					if (n_stamp == '0) t_ext = 1'b1;
				end
				PH_EXT2LEN: begin
					n_hdr = hdr_q - 10'sd1;
					if (byte_s1[6:0] != 7'd0) n_phase = PH_IDEXT;
					else t_finish = 1'b1;
				end
				PH_IDEXT: begin
					if (!byte_s1[7]) n_code = {code_q[7:0], 8'h00};
					n_hdr = hdr_q - 10'sd1; t_finish = 1'b1;
				end
				PH_HSKIP: begin
					n_hdr = hdr_q - 10'sd1;
					if (n_hdr <= 0) t_done = 1'b1;
				end
				PH_PAYLOAD: begin
					n_len = len_q - 18'sd1;
					emit = 1'b1; e_kind = 1'b1; e_last = (n_len <= 0);
					if (n_len <= 0) begin
						n_phase = PH_SEARCH; n_shift = 24'hFF; n_count = '0;
					end
				end
				default: begin
					n_phase = PH_SEARCH; n_shift = 24'hFF; n_count = '0;
				end
			endcase

			// Tail of the header: MPEG-2 optional flags, extension, header skip, then the header item.
			if (t_flags) begin
				if (n_hflags[5:0] != 6'd0 && n_hdr == 0) n_hflags = {n_hflags[7:6], 6'd0};
				if (n_hflags[0]) n_phase = PH_PESEXT;
				else t_finish = 1'b1;
			end
			if (t_ext) begin
				if (n_eflags[0]) n_phase = PH_EXT2LEN;
				else t_finish = 1'b1;
			end
			if (t_finish) begin
				if (n_hdr < 0) begin
					n_phase = PH_SEARCH; n_shift = 24'hFF; n_count = '0;
				end else if (n_hdr > 0) begin
					n_phase = PH_HSKIP;
				end else begin
					t_done = 1'b1;
				end
			end
			if (t_done) begin
				if (n_len < 0) begin
					n_phase = PH_SEARCH; n_shift = 24'hFF; n_count = '0;
				end else begin
					emit = 1'b1; e_kind = 1'b0; e_last = (n_len == 0);
					if (n_len == 0) begin
						n_phase = PH_SEARCH; n_shift = 24'hFF; n_count = '0;
					end else begin
						n_phase = PH_PAYLOAD;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SEARCH;
			shift_q  <= 24'hFF;
			count_q  <= '0;
			code_q   <= '0;
			len_q    <= '0;
			hdr_q    <= '0;
			hflags_q <= '0;
			eflags_q <= '0;
			stamp_q  <= '0;
			fidx_q   <= '0;
			ptsv_q   <= 1'b0;
			pts_q    <= '0;
			dts_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				phase_q  <= n_phase;
				shift_q  <= n_shift;
				count_q  <= n_count;
				code_q   <= n_code;
				len_q    <= n_len;
				hdr_q    <= n_hdr;
				hflags_q <= n_hflags;
				eflags_q <= n_eflags;
				stamp_q  <= n_stamp;
				fidx_q   <= n_fidx;
				ptsv_q   <= n_ptsv;
				pts_q    <= n_pts;
				dts_q    <= n_dts;
				out_valid_q <= emit;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			kind_q     <= e_kind;
			id_q       <= n_code;
			ptsv_out_q <= e_kind ? 1'b0 : n_ptsv;
			pts_out_q  <= e_kind ? '0 : n_pts;
			dts_out_q  <= e_kind ? '0 : n_dts;
			plen_q     <= e_kind ? 16'd0 : n_len[15:0];
			pbyte_q    <= e_kind ? byte_s1 : 8'd0;
			last_q     <= e_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign stream_id      = id_q;
	assign pts_valid      = ptsv_out_q;
	assign pts            = pts_out_q;
	assign dts            = dts_out_q;
	assign payload_length = plen_q;
	assign payload_byte   = pbyte_q;
	assign last           = last_q;

`include "pes_packet_header_parser_assert.svh"

	`PPP_ASSERT_NOW(a_stall_needs_item, in_stall, valid_s1, "input stalled with empty register")
	`PPP_ASSERT_NOW(a_payload_len, phase_q == PH_PAYLOAD, len_q > 0, "payload with no bytes left")
	`PPP_ASSERT_NOW(a_payload_clean, out_valid && kind, !pts_valid && payload_length == 16'd0,
		"payload item carries header fields")
	`PPP_ASSERT_NOW(a_header_last, out_valid && !kind, last == (payload_length == 16'd0),
		"header last flag disagrees with length")

endmodule

// ===== tb/sv/pes_packet_header_parser_checker.sv =====
// ----------------------------------------------------------------------------
// pes_packet_header_parser_checker
// Watches the byte, item and register channels of the PES header parser.
// It predicts the header and payload items that each accepted byte causes,
// and compares every item that leaves the block with the oldest one predicted.
// ----------------------------------------------------------------------------
module pes_packet_header_parser_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  ppp_pkg::byte_t        in_byte,
	input  logic                  restart,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic                  kind,
	input  logic [15:0]           stream_id,
	input  logic                  pts_valid,
	input  ppp_pkg::stamp_t       pts,
	input  ppp_pkg::stamp_t       dts,
	input  logic [15:0]           payload_length,
	input  ppp_pkg::byte_t        payload_byte,
	input  logic                  last,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	input  logic                  pready,
	output int                    mismatches,
	output int                    items_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import ppp_pkg::*;

	typedef enum logic [4:0] {
		P_HUNT, P_LEN_HI, P_LEN_LO, P_SKIP, P_STUFF, P_BUF1, P_BUF2, P_PTS1, P_DTS1,
		P_FLAGS, P_HLEN, P_PTS2, P_DTS2, P_PESEXT, P_EXTSKIP, P_EXT2LEN, P_IDEXT,
		P_HSKIP, P_PAYLOAD
	} phase_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] sid;
		logic        pv;
		stamp_t      pts;
		stamp_t      dts;
		logic [15:0] plen;
		byte_t       pbyte;
		logic        last;
	} pes_item_t;

	pes_item_t   pes_items_due[$];
	pes_item_t   made;
	logic [19:0] hunt_limit;
	logic [23:0] code_shift;
	logic [19:0] hunt_count;
	phase_t      phase;
	logic [15:0] code;
	int          bytes_left;
	int          hdr_left;
	logic [7:0]  hdr_flags;
	logic [7:0]  ext_flags;
	logic [39:0] stamp_sh;
	logic [3:0]  stamp_idx;
	logic [33:0] pts_held;
	logic [32:0] dts_held;

	function automatic stamp_t decode_stamp(input logic [39:0] s);
		return {s[35:33], s[31:17], s[15:1]};
	endfunction

	function void rehunt();
		phase = P_HUNT;
		code_shift = 24'hFF;
		hunt_count = '0;
	endfunction

	function bit header_item();
		if (bytes_left < 0) begin
			rehunt();
			return 0;
		end
		made = '0;
		made.sid = code;
		made.pv = pts_held[33];
		made.pts = pts_held[32:0];
		made.dts = dts_held;
		made.plen = bytes_left[15:0];
		made.last = (bytes_left == 0);
		if (bytes_left == 0)
			rehunt();
		else
			phase = P_PAYLOAD;
		return 1;
	endfunction

	function bit close_m2();
		if (hdr_left < 0) begin
			rehunt();
			return 0;
		end
		if (hdr_left > 0) begin
			phase = P_HSKIP;
			return 0;
		end
		return header_item();
	endfunction

	function bit after_stamps();
		if ((hdr_flags & 8'h3F) != 0 && hdr_left == 0)
			hdr_flags &= 8'hC0;
		if (hdr_flags[0]) begin
			phase = P_PESEXT;
			return 0;
		end
		return close_m2();
	endfunction

	function bit after_ext();
		if (ext_flags[0]) begin
			phase = P_EXT2LEN;
			return 0;
		end
		return close_m2();
	endfunction

	function bit m1_first(input logic [7:0] c);
		if (c[7:5] == 3'b001) begin
			stamp_sh = {32'd0, c};
			stamp_idx = 4'd1;
			phase = P_PTS1;
			return 0;
		end
		if (c[7:6] == 2'b10) begin
			phase = P_FLAGS;
			return 0;
		end
		if (c == 8'h0F)
			return header_item();
		rehunt();
		return 0;
	endfunction

	function bit stamp_byte(input logic [7:0] b);
		stamp_sh = {stamp_sh[31:0], b};
		stamp_idx = stamp_idx + 4'd1;
		return stamp_idx >= 4'd5;
	endfunction

	// Advances the parser by one accepted beat; returns 1 when an item is made.
	function bit parse_beat(input logic [7:0] b, input logic rs);
		logic [3:0] bits;
		int         skip;
		if (rs) begin
			rehunt();
			return 0;
		end
		case (phase)
			P_HUNT: begin
				hunt_count = hunt_count + 20'd1;
				if (code_shift == 24'h1) begin
					code = {8'h01, b};
					rehunt();
					if (code != CODE_PACK && code != CODE_SYSTEM)
						phase = P_LEN_HI;
					return 0;
				end
				code_shift = {code_shift[15:0], b};
				if (hunt_count >= hunt_limit)
					rehunt();
				return 0;
			end
			P_LEN_HI: begin
				bytes_left = int'(b) << 8;
				phase = P_LEN_LO;
				return 0;
			end
			P_LEN_LO: begin
				bytes_left |= int'(b);
				if (code == CODE_PADDING || code == CODE_PRIV2 || code == CODE_MAP) begin
					if (bytes_left == 0)
						rehunt();
					else
						phase = P_SKIP;
				end else if ((code >= CODE_AUDIO_LO && code <= CODE_VIDEO_HI) ||
				             code == CODE_PRIV1 || code == CODE_EXT) begin
					pts_held = '0;
					dts_held = '0;
					if (bytes_left < 1)
						rehunt();
					else
						phase = P_STUFF;
				end else begin
					rehunt();
				end
				return 0;
			end
			P_SKIP: begin
				bytes_left--;
				if (bytes_left <= 0)
					rehunt();
				return 0;
			end
			P_STUFF: begin
				bytes_left--;
				if (b == 8'hFF) begin
					if (bytes_left < 1)
						rehunt();
					return 0;
				end
				if (b[7:6] == 2'b01) begin
					phase = P_BUF1;
					return 0;
				end
				return m1_first(b);
			end
			P_BUF1: begin
				phase = P_BUF2;
				return 0;
			end
			P_BUF2: begin
				bytes_left -= 2;
				return m1_first(b);
			end
			P_PTS1: begin
				if (!stamp_byte(b))
					return 0;
				pts_held = {1'b1, decode_stamp(stamp_sh)};
				dts_held = pts_held[32:0];
				bytes_left -= 4;
				if (stamp_sh[36]) begin
					stamp_idx = '0;
					phase = P_DTS1;
					return 0;
				end
				return header_item();
			end
			P_DTS1: begin
				if (!stamp_byte(b))
					return 0;
				dts_held = decode_stamp(stamp_sh);
				bytes_left -= 5;
				return header_item();
			end
			P_FLAGS: begin
				hdr_flags = b;
				phase = P_HLEN;
				return 0;
			end
			P_HLEN: begin
				bytes_left -= 2;
				hdr_left = int'(b);
				if (hdr_left > bytes_left) begin
					rehunt();
					return 0;
				end
				bytes_left -= hdr_left;
				if (hdr_flags[7]) begin
					stamp_idx = '0;
					phase = P_PTS2;
					return 0;
				end
				return after_stamps();
			end
			P_PTS2: begin
				if (!stamp_byte(b))
					return 0;
				pts_held = {1'b1, decode_stamp(stamp_sh)};
				dts_held = pts_held[32:0];
				hdr_left -= 5;
				if (hdr_flags[6]) begin
					stamp_idx = '0;
					phase = P_DTS2;
					return 0;
				end
				return after_stamps();
			end
			P_DTS2: begin
				if (!stamp_byte(b))
					return 0;
				dts_held = decode_stamp(stamp_sh);
				hdr_left -= 5;
				return after_stamps();
			end
			P_PESEXT: begin
				hdr_left--;
				bits = b[7:4] & 4'hB;
				skip = int'(bits) + int'(bits & 4'h9);
				if (b[6] || skip > hdr_left) begin
					ext_flags = '0;
					return after_ext();
				end
				ext_flags = b;
				hdr_left -= skip;
				if (skip == 0)
					return after_ext();
				stamp_sh = 40'(skip);
				phase = P_EXTSKIP;
				return 0;
			end
			P_EXTSKIP: begin
				stamp_sh = stamp_sh - 40'd1;
				if (stamp_sh == '0)
					return after_ext();
				return 0;
			end
			P_EXT2LEN: begin
				hdr_left--;
				if (b[6:0] != 0) begin
					phase = P_IDEXT;
					return 0;
				end
				return close_m2();
			end
			P_IDEXT: begin
				if (!b[7])
					code = {code[7:0], 8'h00};
				hdr_left--;
				return close_m2();
			end
			P_HSKIP: begin
				hdr_left--;
				if (hdr_left <= 0)
					return header_item();
				return 0;
			end
			P_PAYLOAD: begin
				bytes_left--;
				made = '0;
				made.kind = 1'b1;
				made.sid = code;
				made.pbyte = b;
				made.last = (bytes_left <= 0);
				if (bytes_left <= 0)
					rehunt();
				return 1;
			end
			default: begin
				rehunt();
				return 0;
			end
		endcase
	endfunction

	task automatic compare(input string name, input logic [32:0] want, input logic [32:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pes_item_t want;
		if (!arst_n) begin
			hunt_limit = SYNC_LIMIT_RESET;
			rehunt();
			code = '0;
			bytes_left = 0;
			hdr_left = 0;
			hdr_flags = '0;
			ext_flags = '0;
			stamp_sh = '0;
			stamp_idx = '0;
			pts_held = '0;
			dts_held = '0;
			pes_items_due.delete();
			mismatches = 0;
			items_pending = 0;
		end else begin
			// An item leaving now was caused by a byte taken at an earlier edge.
			if (out_valid && !out_stall) begin
				if (pes_items_due.size() == 0) begin
					$display("%0t: unexpected item, expected none, actual kind %b id %h",
					         $time, kind, stream_id);
					mismatches++;
				end else begin
					want = pes_items_due.pop_front();
					compare("kind", 33'(want.kind), 33'(kind));
					compare("stream_id", 33'(want.sid), 33'(stream_id));
					compare("pts_valid", 33'(want.pv), 33'(pts_valid));
					compare("pts", want.pts, pts);
					compare("dts", want.dts, dts);
					compare("payload_length", 33'(want.plen), 33'(payload_length));
					compare("payload_byte", 33'(want.pbyte), 33'(payload_byte));
					compare("last", 33'(want.last), 33'(last));
				end
			end
			if (in_valid && !in_stall) begin
				if (parse_beat(in_byte, restart))
					pes_items_due.insert(pes_items_due.size(), made);
			end
			if (psel && penable && pwrite && pready && paddr[2] == REG_SYNC_LIMIT)
				hunt_limit = pwdata[19:0];
			items_pending = pes_items_due.size();
		end
	end

endmodule

// ===== tb/sv/pes_packet_header_parser_tb.sv =====
// ----------------------------------------------------------------------------
// pes_packet_header_parser_tb
// Drives program-stream bytes into the PES header parser: packs, system
// headers, skipped packets, MPEG-1 and MPEG-2 PES packets with random content,
// broken packets, restarts and noise, under several hunt limits, with random
// gaps and stalls on both channels. The checker beside the block does the
// prediction and comparison; this module only makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module pes_packet_header_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ppp_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam logic [7:0] M1_NO_STAMP = 8'h0F;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	byte_t       in_byte;
	logic        restart;
	logic        out_valid;
	logic        out_stall;
	logic        kind;
	logic [15:0] stream_id;
	logic        pts_valid;
	stamp_t      pts;
	stamp_t      dts;
	logic [15:0] payload_length;
	byte_t       payload_byte;
	logic        last;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          mismatches;
	int          items_pending;
	int          cycles;
	logic        long_hold;

	// Each beat is {restart, byte}.
	logic [8:0]  stream_beats[$];

	pes_packet_header_parser uut (.*);
	pes_packet_header_parser_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Receiver: random stall before each item, with quiet stretches and one long hold.
	initial begin
		int n;
		int k;
		bit busy;
		out_stall = 1'b0;
		busy = 1'b1;
		k = 0;
		@(posedge arst_n);
		forever begin
			if (k % 40 == 0)
				busy = ($urandom_range(0, 3) != 0);
			k++;
			n = busy ? $urandom_range(0, 18) : 0;
			if (long_hold) begin
				n = 600;
				long_hold = 1'b0;
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic add(input logic [7:0] b);
		stream_beats.insert(stream_beats.size(), {1'b0, b});
	endtask

	task automatic add_code(input logic [7:0] c);
		add(8'h00);
		add(8'h00);
		add(8'h01);
		add(c);
	endtask

	task automatic add_restart();
		stream_beats.insert(stream_beats.size(), {1'b1, 8'($urandom)});
	endtask

	task automatic stamp_bytes(ref logic [7:0] h[$], input logic [3:0] pre,
	                          input logic [32:0] v);
		h.insert(h.size(), {pre, v[32:30], 1'b1});
		h.insert(h.size(), v[29:22]);
		h.insert(h.size(), {v[21:15], 1'b1});
		h.insert(h.size(), v[14:7]);
		h.insert(h.size(), {v[6:0], 1'b1});
	endtask

	function automatic logic [32:0] rand_stamp();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return {1'($urandom), 32'($urandom)};
		endcase
	endfunction

	// One PES packet. stamps: 0 none, 1 PTS, 2 PTS and DTS, 3 MPEG-2 DTS flag alone.
	// Corruption 1 shrinks or stretches the length, 2 overwrites a header byte.
	task automatic add_pes(input logic [7:0] c, input bit mpeg2, input int stamps,
	                       input bit ext, input int npay, input int corrupt);
		logic [7:0] h[$];
		logic [7:0] d[$];
		logic [7:0] e;
		logic [3:0] bits;
		int         len;
		int         skip;
		if (!mpeg2) begin
			repeat ($urandom_range(0, 3)) h.insert(h.size(), 8'hFF);
			if ($urandom_range(0, 1)) begin
				h.insert(h.size(), {2'b01, 6'($urandom)});
				h.insert(h.size(), 8'($urandom));
			end
			if (stamps == 1)
				stamp_bytes(h, 4'h2, rand_stamp());
			else if (stamps == 2) begin
				stamp_bytes(h, 4'h3, rand_stamp());
				stamp_bytes(h, 4'h1, rand_stamp());
			end else
				h.insert(h.size(), M1_NO_STAMP);
		end else begin
			h.insert(h.size(), {2'b10, 6'($urandom)});
			if (stamps == 1 || stamps == 2)
				stamp_bytes(d, stamps == 2 ? 4'h3 : 4'h2, rand_stamp());
			if (stamps == 2)
				stamp_bytes(d, 4'h1, rand_stamp());
			if (ext) begin
				e = 8'($urandom);
				if ($urandom_range(0, 5) != 0)
					e[6] = 1'b0;
				d.insert(d.size(), e);
				bits = e[7:4] & 4'hB;
				skip = int'(bits) + int'(bits & 4'h9);
				if (!e[6])
					repeat (skip) d.insert(d.size(), 8'($urandom));
				if (e[0]) begin
					d.insert(d.size(), $urandom_range(0, 3) == 0 ? 8'h80 :
					         {1'b1, 7'($urandom_range(1, 127))});
					if (d[$][6:0] != 0)
						d.insert(d.size(), 8'($urandom));
				end
			end
			repeat ($urandom_range(0, 2)) d.insert(d.size(), 8'hFF);
			h.insert(h.size(), {stamps == 1 || stamps == 2, stamps >= 2, 5'($urandom), ext});
			h.insert(h.size(), 8'(d.size()));
			foreach (d[i]) h.insert(h.size(), d[i]);
		end
		len = h.size() + npay;
		if (corrupt == 1)
			len = len + $urandom_range(0, 6) - 3;
		if (len < 0)
			len = 0;
		if (corrupt == 2)
			h[$urandom_range(0, h.size() - 1)] = 8'($urandom);
		add_code(c);
		add(8'(len >> 8));
		add(8'(len));
		foreach (h[i]) add(h[i]);
		repeat (npay) add(8'($urandom));
	endtask

	task automatic add_skipped(input logic [7:0] c, input int n);
		add_code(c);
		add(8'(n >> 8));
		add(8'(n));
		repeat (n) add(8'($urandom));
	endtask

	function automatic logic [7:0] rand_pes_code();
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(8'hC0, 8'hDF));
			1: return 8'($urandom_range(8'hE0, 8'hEF));
			2: return CODE_PRIV1[7:0];
			default: return CODE_EXT[7:0];
		endcase
	endfunction

	task automatic add_random(input int target);
		int r;
		while (stream_beats.size() < target) begin
			r = $urandom_range(0, 99);
			if (r < 60)
				add_pes(rand_pes_code(), 1'($urandom_range(0, 1)), $urandom_range(0, 3),
				        1'($urandom_range(0, 1)),
				        $urandom_range(0, 19) == 0 ? $urandom_range(0, 40) : $urandom_range(0, 8),
				        $urandom_range(0, 9) == 0 ? $urandom_range(1, 2) : 0);
			else if (r < 68)
				add_skipped($urandom_range(0, 2) == 0 ? CODE_MAP[7:0] :
				            ($urandom_range(0, 1) ? CODE_PADDING[7:0] : CODE_PRIV2[7:0]),
				            $urandom_range(0, 6));
			else if (r < 76) begin
				add_code($urandom_range(0, 1) ? CODE_PACK[7:0] : CODE_SYSTEM[7:0]);
				repeat ($urandom_range(0, 6)) add(8'($urandom));
			end else if (r < 80)
				add_skipped(8'($urandom), $urandom_range(0, 2));
			else if (r < 85)
				add_restart();
			else
				repeat ($urandom_range(1, 6)) add($urandom_range(0, 1) ? 8'h00 : 8'($urandom));
		end
	endtask

	// Sends the queued beats with random gaps; quiet stretches come and go.
	task automatic send_all();
		logic [8:0] bt;
		int gap;
		int k;
		bit busy;
		k = 0;
		busy = 1'b1;
		while (stream_beats.size() > 0) begin
			bt = stream_beats.pop_front();
			if (k % 50 == 0)
				busy = ($urandom_range(0, 3) != 0);
			k++;
			gap = busy ? $urandom_range(0, 18) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1'b1;
			restart <= bt[8];
			in_byte <= bt[7:0];
			do @(posedge clk); while (in_stall);
		end
		in_valid <= 1'b0;
	endtask

	// The checker counts the last beat at the edge it is taken, so wait past that edge.
	task automatic drain();
		@(posedge clk);
		while (items_pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_limit(input logic [19:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(REG_SYNC_LIMIT) << 2;
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		logic [19:0] limits[$];
		limits = '{20'd1, 20'hFFFFF, 20'd0, 20'd5, 20'd4, 20'd100000, 20'd12};
		long_hold = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = '0;
		restart = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: PES, padding, map and pack codes, stamp forms, broken headers, restarts.
		add_pes(8'hC0, 1'b0, 1, 1'b0, 2, 0);
		add_pes(8'hEF, 1'b1, 2, 1'b1, 1, 0);
		add_pes(CODE_PRIV1[7:0], 1'b1, 3, 1'b0, 0, 0);
		add_pes(CODE_EXT[7:0], 1'b1, 1, 1'b1, 1, 0);
		add_skipped(CODE_PADDING[7:0], 0);
		add_skipped(CODE_MAP[7:0], 2);
		add_code(CODE_PACK[7:0]);
		add_code(8'hC5);
		add(8'h00);
		add(8'h03);
		add(8'h10);
		add_code(8'hE0);
		add(8'hFF);
		add(8'hFF);
		add(M1_NO_STAMP);
		add_restart();
		add_code(8'hDF);
		add(8'h00);
		add(8'h00);
		send_all();
		drain();

		foreach (limits[i]) begin
			write_limit(limits[i]);
			add_random(170);
			if (i == 3)
				long_hold = 1'b1;
			send_all();
			drain();
		end
		add_code(8'hE0);
		add(8'hFF);
		add(8'hFF);
		add(M1_NO_STAMP);
		add(8'h11);
		add_restart();
		send_all();
		drain();

		if (mismatches == 0 && items_pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
